### rtl/bdll_pkg.sv
// ---------------------------------------------------------------------------
// bdll_pkg
// Shared constants and types for the bounded list with cursor.
// ---------------------------------------------------------------------------
package bdll_pkg;

    localparam int CAPACITY_DEFAULT   = 64;
    localparam int DATA_WIDTH_DEFAULT = 32;

    // operation codes on the kind field
    localparam logic [2:0] KIND_APPEND  = 3'd0;
    localparam logic [2:0] KIND_PREPEND = 3'd1;
    localparam logic [2:0] KIND_INSERT  = 3'd2;
    localparam logic [2:0] KIND_DELETE  = 3'd3;
    localparam logic [2:0] KIND_NEXT    = 3'd4;
    localparam logic [2:0] KIND_PREV    = 3'd5;

    // result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_PLACE,
        S_READ,
        S_LOAD
    } state_t;

endpackage

### rtl/bdll_ram.sv
// ---------------------------------------------------------------------------
// bdll_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
module bdll_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/bounded_doubly_linked_list_top.sv
// after a word is accepted, inserts and prepends shift the entries from the position up and then
// place the value, appends only place it, deletes shift the later entries down, and cursor moves
// and rejected words go straight to the read and load states; the shift moves one entry a cycle
// one word in flight at a time; the next word is taken in the cycle after the result is
// loaded, even while that result waits
// reset: count zero, cursor invalid; the element ram needs no clearing
// ---------------------------------------------------------------------------
// bounded_doubly_linked_list_top
// Ordered list of up to CAPACITY values with a cursor, held in a ram.
// ---------------------------------------------------------------------------
module bounded_doubly_linked_list_top #(
    parameter int CAPACITY   = bdll_pkg::CAPACITY_DEFAULT,
    parameter int DATA_WIDTH = bdll_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  kind,
    input  logic [31:0] value,
    input  logic [5:0]  position,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [6:0]  count,
    output logic        cursor_valid,
    output logic [5:0]  cursor_position,
    output logic [31:0] cursor_value
);

    localparam int IW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > 6) ? CW : 6;

    bdll_pkg::state_t state_reg, state_next;

    logic [CW-1:0]         count_reg;
    logic [IW-1:0]         cur_idx_reg;
    logic                  cur_pres_reg;
    logic [CW-1:0]         rem_reg;
    logic                  pend_reg;
    logic [IW-1:0]         src_reg;
    logic [IW-1:0]         pend_addr_reg;
    logic                  ins_reg;
    logic                  place_reg;
    logic [IW-1:0]         place_p_reg;
    logic [DATA_WIDTH-1:0] value_reg;
    logic [1:0]            status_reg;

    // decode of the incoming word
    logic [1:0]    dec_status;
    logic          dec_ins;
    logic          dec_place;
    logic [IW-1:0] dec_p;
    logic [CW-1:0] dec_rem;
    logic [IW-1:0] dec_src;
    logic [CW-1:0] dec_count;
    logic [IW-1:0] dec_idx;
    logic          dec_pres;
    logic          full;
    logic          pos_ok;
    logic [IW-1:0] pos_i;
    logic [CW-1:0] del_count;

    logic                  accept;
    logic                  ram_we;
    logic [IW-1:0]         ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic                  ram_re;
    logic [IW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;
    logic                  load_out;

    assign in_ready = (state_reg == bdll_pkg::S_IDLE);
    assign accept   = in_valid && in_ready;

    assign full      = (count_reg == CW'(CAPACITY));
    assign pos_ok    = (CMPW'(position) < CMPW'(count_reg));
    assign pos_i     = IW'(position);
    assign del_count = count_reg - CW'(1);

    always_comb
    begin
        dec_status = bdll_pkg::ST_DONE;
        dec_ins    = 1'b0;
        dec_place  = 1'b0;
        dec_p      = '0;
        dec_rem    = '0;
        dec_src    = '0;
        dec_count  = count_reg;
        dec_idx    = cur_idx_reg;
        dec_pres   = cur_pres_reg;
        case (kind)
            bdll_pkg::KIND_APPEND, bdll_pkg::KIND_PREPEND, bdll_pkg::KIND_INSERT:
            begin
                if (kind == bdll_pkg::KIND_INSERT && !pos_ok)
                begin
                    dec_status = bdll_pkg::ST_RANGE;
                end
                else if (full)
                begin
                    dec_status = bdll_pkg::ST_FULL;
                end
                else
                begin
                    dec_place = 1'b1;
                    dec_ins   = 1'b1;
                    if (kind == bdll_pkg::KIND_APPEND)
                    begin
                        dec_p = IW'(count_reg);
                    end
                    else if (kind == bdll_pkg::KIND_PREPEND)
                    begin
                        dec_p = '0;
                    end
                    else
                    begin
                        dec_p = pos_i;
                    end
                    dec_rem   = count_reg - CW'(dec_p);
                    dec_src   = IW'(count_reg - CW'(1));
                    dec_count = count_reg + CW'(1);
                    if (!cur_pres_reg)
                    begin
                        dec_pres = 1'b1;
                        dec_idx  = dec_p;
                    end
                    else if (cur_idx_reg >= dec_p)
                    begin
                        dec_idx = cur_idx_reg + IW'(1);
                    end
                end
            end
            bdll_pkg::KIND_DELETE:
            begin
                if (!pos_ok)
                begin
                    dec_status = bdll_pkg::ST_RANGE;
                end
                else
                begin
                    dec_p     = pos_i;
                    dec_rem   = del_count - CW'(pos_i);
                    dec_src   = IW'(CW'(pos_i) + CW'(1));
                    dec_count = del_count;
                    if (cur_pres_reg)
                    begin
                        if (cur_idx_reg > pos_i)
                        begin
                            dec_idx = cur_idx_reg - IW'(1);
                        end
                        else if (cur_idx_reg == pos_i)
                        begin
                            if (CW'(pos_i) < del_count)
                            begin
                                dec_idx = pos_i;
                            end
                            else if (pos_i != '0)
                            begin
                                dec_idx = pos_i - IW'(1);
                            end
                            else
                            begin
                                dec_pres = 1'b0;
                                dec_idx  = '0;
                            end
                        end
                    end
                end
            end
            bdll_pkg::KIND_NEXT:
            begin
                if (cur_pres_reg && (CW'(cur_idx_reg) + CW'(1) < count_reg))
                begin
                    dec_idx = cur_idx_reg + IW'(1);
                end
            end
            bdll_pkg::KIND_PREV:
            begin
                if (cur_pres_reg && cur_idx_reg != '0)
                begin
                    dec_idx = cur_idx_reg - IW'(1);
                end
            end
            default:
            begin
                dec_status = bdll_pkg::ST_DONE;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bdll_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (dec_rem != '0)
                    begin
                        state_next = bdll_pkg::S_SHIFT;
                    end
                    else if (dec_place)
                    begin
                        state_next = bdll_pkg::S_PLACE;
                    end
                    else
                    begin
                        state_next = bdll_pkg::S_READ;
                    end
                end
            end
            bdll_pkg::S_SHIFT:
            begin
                if (rem_reg == '0)
                begin
                    state_next = place_reg ? bdll_pkg::S_PLACE : bdll_pkg::S_READ;
                end
            end
            bdll_pkg::S_PLACE:
            begin
                state_next = bdll_pkg::S_READ;
            end
            bdll_pkg::S_READ:
            begin
                state_next = bdll_pkg::S_LOAD;
            end
            bdll_pkg::S_LOAD:
            begin
                if (!out_valid || out_ready)
                begin
                    state_next = bdll_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bdll_pkg::S_IDLE;
            end
        endcase
    end

    // ram control
    always_comb
    begin
        ram_re    = 1'b0;
        ram_raddr = src_reg;
        load_out  = 1'b0;
        case (state_reg)
            bdll_pkg::S_SHIFT:
            begin
                ram_re = (rem_reg != '0);
            end
            bdll_pkg::S_READ:
            begin
                ram_re    = 1'b1;
                ram_raddr = cur_idx_reg;
            end
            bdll_pkg::S_LOAD:
            begin
                load_out = !out_valid || out_ready;
            end
            default:
            begin
                ram_re = 1'b0;
            end
        endcase
        // a moved word lands one slot up for insert, one down for delete
        ram_we    = pend_reg || (state_reg == bdll_pkg::S_PLACE);
        ram_waddr = place_p_reg;
        ram_wdata = value_reg;
        if (pend_reg)
        begin
            ram_waddr = ins_reg ? pend_addr_reg + IW'(1) : pend_addr_reg - IW'(1);
            ram_wdata = ram_rdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= bdll_pkg::S_IDLE;
            count_reg    <= '0;
            cur_idx_reg  <= '0;
            cur_pres_reg <= 1'b0;
            rem_reg      <= '0;
            pend_reg     <= 1'b0;
            out_valid    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= (state_reg == bdll_pkg::S_SHIFT) && (rem_reg != '0);
            if (accept)
            begin
                count_reg    <= dec_count;
                cur_idx_reg  <= dec_idx;
                cur_pres_reg <= dec_pres;
                rem_reg      <= dec_rem;
            end
            else if (state_reg == bdll_pkg::S_SHIFT && rem_reg != '0)
            begin
                rem_reg <= rem_reg - CW'(1);
            end
            if (load_out)
            begin
                out_valid <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ins_reg     <= dec_ins;
            place_reg   <= dec_place;
            place_p_reg <= dec_p;
            src_reg     <= dec_src;
            value_reg   <= DATA_WIDTH'(value);
            status_reg  <= dec_status;
        end
        else if (state_reg == bdll_pkg::S_SHIFT && rem_reg != '0)
        begin
            src_reg <= ins_reg ? src_reg - IW'(1) : src_reg + IW'(1);
        end
        pend_addr_reg <= src_reg;
        if (load_out)
        begin
            status          <= status_reg;
            count           <= 7'(count_reg);
            cursor_valid    <= cur_pres_reg;
            cursor_position <= cur_pres_reg ? 6'(cur_idx_reg) : 6'd0;
            cursor_value    <= cur_pres_reg ? 32'(ram_rdata) : 32'd0;
        end
    end

    bdll_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule
